### hdl/c2c_pkg.sv
// ============================================================================
// c2c_pkg
// Shared codes and field widths for the CSC to CSR converter.
// ============================================================================
package c2c_pkg;

    localparam int SLOT_W   = 13;
    localparam int PTR_W    = 13;
    localparam int ROW_W    = 8;
    localparam int DATA_W   = 64;
    localparam int DIMREG_W = 9;
    localparam int NNZREG_W = 13;
    localparam int CFGIDX_W = 2;
    localparam int CFGDAT_W = 13;

    localparam logic [1:0] MODE_LOAD_PTR   = 2'd0;
    localparam logic [1:0] MODE_LOAD_ENTRY = 2'd1;
    localparam logic [1:0] MODE_CONVERT    = 2'd2;
    localparam logic [1:0] MODE_READ       = 2'd3;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_RANGE     = 2'd1;
    localparam logic [1:0] STAT_NOT_READY = 2'd2;

    localparam logic [CFGIDX_W-1:0] REG_NUM_ROWS     = 2'd0;
    localparam logic [CFGIDX_W-1:0] REG_NUM_COLS     = 2'd1;
    localparam logic [CFGIDX_W-1:0] REG_NUM_NONZEROS = 2'd2;

endpackage

### hdl/c2c_ram.sv
// ============================================================================
// c2c_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ============================================================================
module c2c_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

### hdl/csc_to_csr_converter_unit.sv
// ============================================================================
// csc_to_csr_converter_unit
// Converts a sparse matrix held in compressed-column form to compressed-row.
// ============================================================================
// Usage:
//   A request is taken at a rising edge with start high and busy low. Mode
//   picks the job: load a column pointer, load one nonzero (row, value),
//   convert, or read back one CSR slot. Every request gives one result on
//   status/col_index/out_value/row_pointer, marked by done for one cycle.
//   The receiver cannot stall; the result is gone after that cycle.
//   Loads and reads: result in the cycle after the request, busy stays low,
//   so one request per cycle is sustained.
//   Convert: busy stays high while the sequencer works through the memories
//   over one write port and one read port each: it clears the row pointers,
//   counts the entries of each row, sums the counts into row pointers, then
//   scatters the entries column by column; entries whose row is out of use
//   are skipped in the count and in the scatter pass.
//   The result follows in the cycle after the last busy cycle.
//   Configuration writes (wr_en, wr_index, wr_data) take effect at once and,
//   like loads, mark the converted data stale: reads answer not-ready until
//   the next convert.
//   Reset clears the registers to rows 1, cols 1, nonzeros 0 and the
//   converted flag. Row pointers 0 to rows are cleared at the start of each
//   convert by a pass; other memories hold what was written.
// ============================================================================
module csc_to_csr_converter_unit #(
    parameter int MAX_DIM    = 256,
    parameter int MAX_NNZ    = 4096,
    parameter int VALUE_BITS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     mode,
    input  logic [c2c_pkg::SLOT_W-1:0]     slot,
    input  logic [c2c_pkg::PTR_W-1:0]      pointer_value,
    input  logic [c2c_pkg::ROW_W-1:0]      row_index,
    input  logic [c2c_pkg::DATA_W-1:0]     entry_value,
    output logic                           done,
    output logic [1:0]                     status,
    output logic [c2c_pkg::ROW_W-1:0]      col_index,
    output logic [c2c_pkg::DATA_W-1:0]     out_value,
    output logic [c2c_pkg::PTR_W-1:0]      row_pointer,
    input  logic                           wr_en,
    input  logic [c2c_pkg::CFGIDX_W-1:0]   wr_index,
    input  logic [c2c_pkg::CFGDAT_W-1:0]   wr_data
);
    // address widths of the row-sized and entry-sized memories
    localparam int DA_W = $clog2(MAX_DIM + 1);
    localparam int NA_W = (MAX_NNZ > 1) ? $clog2(MAX_NNZ) : 1;
    // width of counts up to MAX_NNZ, and of entry walk positions
    localparam int NC_W = $clog2(MAX_NNZ + 1);
    localparam int NW   = (NC_W > c2c_pkg::PTR_W) ? NC_W : c2c_pkg::PTR_W;

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_CNT_RD, S_CNT_ROW, S_CNT_WR, S_PFX_RD, S_PFX_WR,
        S_SC_LO, S_SC_HI, S_SC_HI2, S_SC_RD, S_SC_ROW, S_SC_WR, S_DONE
    } state_t;

    state_t                        state_reg;
    logic [c2c_pkg::DIMREG_W-1:0]  num_rows_reg, num_cols_reg;
    logic [c2c_pkg::NNZREG_W-1:0]  num_nnz_reg;
    logic                          converted_reg;
    logic                          done_reg, ent_reg, rp_reg;
    logic [1:0]                    status_reg;
    logic [DA_W-1:0]               r_reg, c_reg;
    logic [NW-1:0]                 n_reg, hi_reg;
    logic [NC_W-1:0]               sum_reg;
    logic [c2c_pkg::ROW_W-1:0]     row_reg;

    logic [DA_W-1:0] rows_eff, cols_eff;
    logic [NC_W-1:0] nnz_eff;

    assign rows_eff = (32'(num_rows_reg) > MAX_DIM) ? DA_W'(MAX_DIM) : DA_W'(num_rows_reg);
    assign cols_eff = (32'(num_cols_reg) > MAX_DIM) ? DA_W'(MAX_DIM) : DA_W'(num_cols_reg);
    assign nnz_eff  = (32'(num_nnz_reg) > MAX_NNZ) ? NC_W'(MAX_NNZ) : NC_W'(num_nnz_reg);

    logic accept;
    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // ---------------- memory ports ----------------
    logic                      cp_we, cp_re;
    logic [DA_W-1:0]           cp_waddr, cp_raddr;
    logic [c2c_pkg::PTR_W-1:0] cp_q;

    logic                      ir_we, ir_re;
    logic [NA_W-1:0]           ir_waddr, ir_raddr;
    logic [c2c_pkg::ROW_W-1:0] ir_q;
    logic [VALUE_BITS-1:0]     iv_q;

    logic                      rp_we, rp_re;
    logic [DA_W-1:0]           rp_waddr, rp_raddr;
    logic [NC_W-1:0]           rp_wdata, rp_q;

    logic                      cu_we, cu_re;
    logic [DA_W-1:0]           cu_waddr, cu_raddr;
    logic [NC_W-1:0]           cu_wdata, cu_q;

    logic                      oc_we, oc_re;
    logic [NA_W-1:0]           oc_waddr, oc_raddr;
    logic [c2c_pkg::ROW_W-1:0] oc_q;
    logic [VALUE_BITS-1:0]     ov_q;

    logic row_in_range;
    assign row_in_range = (32'(ir_q) < 32'(rows_eff));

    always_comb
    begin
        cp_we    = 1'b0;
        cp_waddr = DA_W'(slot);
        cp_re    = 1'b0;
        cp_raddr = c_reg;
        ir_we    = 1'b0;
        ir_waddr = NA_W'(slot);
        ir_re    = 1'b0;
        ir_raddr = NA_W'(n_reg);
        rp_we    = 1'b0;
        rp_waddr = r_reg;
        rp_wdata = '0;
        rp_re    = 1'b0;
        rp_raddr = DA_W'(slot);
        cu_we    = 1'b0;
        cu_waddr = r_reg;
        cu_wdata = sum_reg;
        cu_re    = 1'b0;
        cu_raddr = DA_W'(ir_q);
        oc_we    = 1'b0;
        oc_waddr = NA_W'(cu_q);
        oc_re    = 1'b0;
        oc_raddr = NA_W'(slot);
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cp_we = (mode == c2c_pkg::MODE_LOAD_PTR) && (32'(slot) <= MAX_DIM);
                    ir_we = (mode == c2c_pkg::MODE_LOAD_ENTRY) && (32'(slot) < MAX_NNZ);
                    if (mode == c2c_pkg::MODE_READ)
                    begin
                        rp_re = 1'b1;
                        oc_re = 1'b1;
                    end
                end
            end
            S_CLR:
            begin
                rp_we = 1'b1;
            end
            S_CNT_RD:
            begin
                ir_re = (32'(n_reg) < 32'(nnz_eff));
            end
            S_CNT_ROW:
            begin
                rp_re    = row_in_range;
                rp_raddr = DA_W'(ir_q);
            end
            S_CNT_WR:
            begin
                rp_we    = 1'b1;
                rp_waddr = DA_W'(row_reg);
                rp_wdata = NC_W'(rp_q + 1'b1);
            end
            S_PFX_RD:
            begin
                // last pointer holds the total
                rp_we    = (r_reg == rows_eff);
                rp_wdata = sum_reg;
                rp_re    = (r_reg != rows_eff);
                rp_raddr = r_reg;
            end
            S_PFX_WR:
            begin
                rp_we    = 1'b1;
                rp_wdata = sum_reg;
                cu_we    = 1'b1;
            end
            S_SC_LO:
            begin
                cp_re = (c_reg != cols_eff);
            end
            S_SC_HI:
            begin
                cp_re    = 1'b1;
                cp_raddr = DA_W'(c_reg + 1'b1);
            end
            S_SC_RD:
            begin
                ir_re = (n_reg < hi_reg);
            end
            S_SC_ROW:
            begin
                rp_re    = row_in_range;
                rp_raddr = DA_W'(ir_q) + DA_W'(1);
                cu_re    = row_in_range;
            end
            S_SC_WR:
            begin
                if (NC_W'(cu_q) < rp_q)
                begin
                    oc_we    = 1'b1;
                    cu_we    = 1'b1;
                    cu_waddr = DA_W'(row_reg);
                    cu_wdata = NC_W'(cu_q + 1'b1);
                end
            end
            default:
            begin
            end
        endcase
    end

    c2c_ram #(.WIDTH(c2c_pkg::PTR_W), .DEPTH(MAX_DIM + 1)) u_colptr (
        .clk(clk), .we(cp_we), .waddr(cp_waddr), .wdata(pointer_value),
        .re(cp_re), .raddr(cp_raddr), .rdata(cp_q));

    c2c_ram #(.WIDTH(c2c_pkg::ROW_W), .DEPTH(MAX_NNZ)) u_in_row (
        .clk(clk), .we(ir_we), .waddr(ir_waddr), .wdata(row_index),
        .re(ir_re), .raddr(ir_raddr), .rdata(ir_q));

    c2c_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_NNZ)) u_in_value (
        .clk(clk), .we(ir_we), .waddr(ir_waddr), .wdata(entry_value[VALUE_BITS-1:0]),
        .re(ir_re), .raddr(ir_raddr), .rdata(iv_q));

    c2c_ram #(.WIDTH(NC_W), .DEPTH(MAX_DIM + 1)) u_rowptr (
        .clk(clk), .we(rp_we), .waddr(rp_waddr), .wdata(rp_wdata),
        .re(rp_re), .raddr(rp_raddr), .rdata(rp_q));

    c2c_ram #(.WIDTH(NC_W), .DEPTH(MAX_DIM + 1)) u_cursor (
        .clk(clk), .we(cu_we), .waddr(cu_waddr), .wdata(cu_wdata),
        .re(cu_re), .raddr(cu_raddr), .rdata(cu_q));

    c2c_ram #(.WIDTH(c2c_pkg::ROW_W), .DEPTH(MAX_NNZ)) u_out_col (
        .clk(clk), .we(oc_we), .waddr(oc_waddr), .wdata(c2c_pkg::ROW_W'(c_reg)),
        .re(oc_re), .raddr(oc_raddr), .rdata(oc_q));

    c2c_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_NNZ)) u_out_value (
        .clk(clk), .we(oc_we), .waddr(oc_waddr), .wdata(iv_q),
        .re(oc_re), .raddr(oc_raddr), .rdata(ov_q));

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            num_rows_reg  <= c2c_pkg::DIMREG_W'(1);
            num_cols_reg  <= c2c_pkg::DIMREG_W'(1);
            num_nnz_reg   <= '0;
            converted_reg <= 1'b0;
            done_reg      <= 1'b0;
            status_reg    <= c2c_pkg::STAT_OK;
            ent_reg       <= 1'b0;
            rp_reg        <= 1'b0;
            r_reg         <= '0;
            c_reg         <= '0;
            n_reg         <= '0;
            hi_reg        <= '0;
            sum_reg       <= '0;
            row_reg       <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            ent_reg  <= 1'b0;
            rp_reg   <= 1'b0;
            if (wr_en)
            begin
                case (wr_index)
                    c2c_pkg::REG_NUM_ROWS:
                    begin
                        num_rows_reg  <= wr_data[c2c_pkg::DIMREG_W-1:0];
                        converted_reg <= 1'b0;
                    end
                    c2c_pkg::REG_NUM_COLS:
                    begin
                        num_cols_reg  <= wr_data[c2c_pkg::DIMREG_W-1:0];
                        converted_reg <= 1'b0;
                    end
                    c2c_pkg::REG_NUM_NONZEROS:
                    begin
                        num_nnz_reg   <= wr_data;
                        converted_reg <= 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        status_reg <= c2c_pkg::STAT_OK;
                        case (mode)
                            c2c_pkg::MODE_LOAD_PTR:
                            begin
                                done_reg <= 1'b1;
                                if (32'(slot) <= MAX_DIM)
                                    converted_reg <= 1'b0;
                                else
                                    status_reg <= c2c_pkg::STAT_RANGE;
                            end
                            c2c_pkg::MODE_LOAD_ENTRY:
                            begin
                                done_reg <= 1'b1;
                                if (32'(slot) < MAX_NNZ)
                                    converted_reg <= 1'b0;
                                else
                                    status_reg <= c2c_pkg::STAT_RANGE;
                            end
                            c2c_pkg::MODE_CONVERT:
                            begin
                                r_reg     <= '0;
                                state_reg <= S_CLR;
                            end
                            default:
                            begin
                                done_reg <= 1'b1;
                                if (!converted_reg)
                                    status_reg <= c2c_pkg::STAT_NOT_READY;
                                else
                                begin
                                    ent_reg <= (32'(slot) < 32'(nnz_eff));
                                    rp_reg  <= (32'(slot) <= 32'(rows_eff));
                                    if (!(32'(slot) < 32'(nnz_eff)) &&
                                        !(32'(slot) <= 32'(rows_eff)))
                                        status_reg <= c2c_pkg::STAT_RANGE;
                                end
                            end
                        endcase
                    end
                end
                S_CLR:
                begin
                    r_reg <= r_reg + 1'b1;
                    if (r_reg == rows_eff)
                    begin
                        n_reg     <= '0;
                        state_reg <= S_CNT_RD;
                    end
                end
                S_CNT_RD:
                begin
                    if (32'(n_reg) < 32'(nnz_eff))
                        state_reg <= S_CNT_ROW;
                    else
                    begin
                        r_reg     <= '0;
                        sum_reg   <= '0;
                        state_reg <= S_PFX_RD;
                    end
                end
                S_CNT_ROW:
                begin
                    row_reg <= ir_q;
                    if (row_in_range)
                        state_reg <= S_CNT_WR;
                    else
                    begin
                        n_reg     <= n_reg + 1'b1;
                        state_reg <= S_CNT_RD;
                    end
                end
                S_CNT_WR:
                begin
                    n_reg     <= n_reg + 1'b1;
                    state_reg <= S_CNT_RD;
                end
                S_PFX_RD:
                begin
                    if (r_reg == rows_eff)
                    begin
                        c_reg     <= '0;
                        state_reg <= S_SC_LO;
                    end
                    else
                        state_reg <= S_PFX_WR;
                end
                S_PFX_WR:
                begin
                    sum_reg   <= NC_W'(sum_reg + rp_q);
                    r_reg     <= r_reg + 1'b1;
                    state_reg <= S_PFX_RD;
                end
                S_SC_LO:
                begin
                    if (c_reg == cols_eff)
                        state_reg <= S_DONE;
                    else
                        state_reg <= S_SC_HI;
                end
                S_SC_HI:
                begin
                    n_reg     <= NW'(cp_q);
                    state_reg <= S_SC_HI2;
                end
                S_SC_HI2:
                begin
                    // clip the column end to the entry count
                    hi_reg    <= (32'(cp_q) > 32'(nnz_eff)) ? NW'(nnz_eff) : NW'(cp_q);
                    state_reg <= S_SC_RD;
                end
                S_SC_RD:
                begin
                    if (n_reg < hi_reg)
                        state_reg <= S_SC_ROW;
                    else
                    begin
                        c_reg     <= c_reg + 1'b1;
                        state_reg <= S_SC_LO;
                    end
                end
                S_SC_ROW:
                begin
                    row_reg <= ir_q;
                    if (row_in_range)
                        state_reg <= S_SC_WR;
                    else
                    begin
                        n_reg     <= n_reg + 1'b1;
                        state_reg <= S_SC_RD;
                    end
                end
                S_SC_WR:
                begin
                    n_reg     <= n_reg + 1'b1;
                    state_reg <= S_SC_RD;
                end
                S_DONE:
                begin
                    converted_reg <= 1'b1;
                    done_reg      <= 1'b1;
                    status_reg    <= c2c_pkg::STAT_OK;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign col_index   = ent_reg ? oc_q : '0;
    assign out_value   = ent_reg ? c2c_pkg::DATA_W'(ov_q) : '0;
    assign row_pointer = rp_reg ? c2c_pkg::PTR_W'(rp_q) : '0;

    // ---------------- checks ----------------
    a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (mode != c2c_pkg::MODE_CONVERT)) |=> done)
        else $error("load or read gave no result in the next cycle");

    a_convert_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (mode == c2c_pkg::MODE_CONVERT)) |=> (busy && !done))
        else $error("convert did not hold busy");

    a_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (ent_reg || rp_reg)) |-> (status == c2c_pkg::STAT_OK))
        else $error("read data shown with an error status");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (done && busy) |-> 1'b0)
        else $error("result while the sequencer is busy");
endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top: CSC to CSR converter bench
// Runs phases of load / convert / read requests against a cycle-free predictor
// of the conversion and checks every result in order, with random start gaps.
// ============================================================================
module tb_top;

    localparam int DIM  = 256;
    localparam int NNZ  = 4096;
    localparam int WDOG = 200000;

    typedef struct packed {
        logic [1:0]                 mode;
        logic [c2c_pkg::SLOT_W-1:0] slot;
        logic [c2c_pkg::PTR_W-1:0]  ptr;
        logic [c2c_pkg::ROW_W-1:0]  row;
        logic [c2c_pkg::DATA_W-1:0] val;
    } req_t;

    typedef struct packed {
        logic [1:0]                 status;
        logic [c2c_pkg::ROW_W-1:0]  col;
        logic [c2c_pkg::DATA_W-1:0] val;
        logic [c2c_pkg::PTR_W-1:0]  rp;
    } res_t;

    logic clk, rst_n;
    logic start, busy, done;
    logic [1:0] mode, status;
    logic [c2c_pkg::SLOT_W-1:0] slot;
    logic [c2c_pkg::PTR_W-1:0] pointer_value, row_pointer;
    logic [c2c_pkg::ROW_W-1:0] row_index, col_index;
    logic [c2c_pkg::DATA_W-1:0] entry_value, out_value;
    logic wr_en;
    logic [c2c_pkg::CFGIDX_W-1:0] wr_index;
    logic [c2c_pkg::CFGDAT_W-1:0] wr_data;

    csc_to_csr_converter_unit u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .slot(slot), .pointer_value(pointer_value), .row_index(row_index),
        .entry_value(entry_value), .done(done), .status(status),
        .col_index(col_index), .out_value(out_value), .row_pointer(row_pointer),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
    );

    // Predictor state: shadow copies of the block's registers and memories.
    logic [c2c_pkg::DIMREG_W-1:0] rows_reg, cols_reg;
    logic [c2c_pkg::NNZREG_W-1:0] nnz_reg;
    logic [c2c_pkg::PTR_W-1:0]  colptr_mem [DIM+1];
    logic [c2c_pkg::ROW_W-1:0]  in_row_mem [NNZ];
    logic [c2c_pkg::DATA_W-1:0] in_val_mem [NNZ];
    logic [c2c_pkg::PTR_W-1:0]  rowptr_mem [DIM+1];
    logic [c2c_pkg::ROW_W-1:0]  csr_col_mem [NNZ];
    logic [c2c_pkg::DATA_W-1:0] csr_val_mem [NNZ];
    bit                         csr_written [NNZ];
    bit                         csr_ready;

    req_t pending_reqs[$];
    res_t expected_results[$];
    req_t cur_req;
    bit   no_gaps;
    bit   failed;
    int   quiet_cycles;

    function automatic int eff_rows();
        return (rows_reg > DIM) ? DIM : int'(rows_reg);
    endfunction

    function automatic int eff_cols();
        return (cols_reg > DIM) ? DIM : int'(cols_reg);
    endfunction

    function automatic int eff_nnz();
        return (nnz_reg > NNZ) ? NNZ : int'(nnz_reg);
    endfunction

    // Count per row, prefix-sum into row pointers, scatter in column order.
    function automatic void run_conversion();
        int rows, cols, nnz, sum, cnt, lo, hi, r;
        int next_free [DIM+1];
        rows = eff_rows();
        cols = eff_cols();
        nnz  = eff_nnz();
        sum  = 0;
        for (int i = 0; i <= DIM; i++) rowptr_mem[i] = '0;
        for (int n = 0; n < nnz; n++)
            if (in_row_mem[n] < rows) rowptr_mem[in_row_mem[n]]++;
        for (int i = 0; i < rows; i++)
        begin
            cnt = rowptr_mem[i];
            rowptr_mem[i] = sum;
            sum += cnt;
        end
        rowptr_mem[rows] = sum;
        for (int i = 0; i <= rows; i++) next_free[i] = rowptr_mem[i];
        for (int c = 0; c < cols; c++)
        begin
            lo = colptr_mem[c];
            hi = colptr_mem[c+1];
            if (hi > nnz) hi = nnz;
            for (int n = lo; n < hi; n++)
            begin
                r = in_row_mem[n];
                if (r >= rows) continue;
                // drop scatters that overflow the row's region
                if (next_free[r] >= rowptr_mem[r+1]) continue;
                csr_col_mem[next_free[r]] = c[7:0];
                csr_val_mem[next_free[r]] = in_val_mem[n];
                csr_written[next_free[r]] = 1'b1;
                next_free[r]++;
            end
        end
        csr_ready = 1'b1;
    endfunction

    function automatic res_t predict_result(req_t q);
        res_t r;
        bit ent_ok, rp_ok;
        r = '0;
        case (q.mode)
            c2c_pkg::MODE_LOAD_PTR:
                if (q.slot <= DIM)
                begin
                    colptr_mem[q.slot] = q.ptr;
                    csr_ready = 1'b0;
                end
                else r.status = c2c_pkg::STAT_RANGE;
            c2c_pkg::MODE_LOAD_ENTRY:
                if (q.slot < NNZ)
                begin
                    in_row_mem[q.slot] = q.row;
                    in_val_mem[q.slot] = q.val;
                    csr_ready = 1'b0;
                end
                else r.status = c2c_pkg::STAT_RANGE;
            c2c_pkg::MODE_CONVERT:
                run_conversion();
            default:
                if (!csr_ready) r.status = c2c_pkg::STAT_NOT_READY;
                else
                begin
                    ent_ok = q.slot < eff_nnz();
                    rp_ok  = q.slot <= eff_rows();
                    if (ent_ok)
                    begin
                        r.col = csr_col_mem[q.slot];
                        r.val = csr_val_mem[q.slot];
                    end
                    if (rp_ok) r.rp = rowptr_mem[q.slot];
                    if (!ent_ok && !rp_ok) r.status = c2c_pkg::STAT_RANGE;
                end
        endcase
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Driver: present the next pending request; drop start when nothing goes.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start         <= 1'b0;
            mode          <= c2c_pkg::MODE_LOAD_PTR;
            slot          <= '0;
            pointer_value <= '0;
            row_index     <= '0;
            entry_value   <= '0;
        end
        else
        begin
            if (start && !busy)
                expected_results.push_back(predict_result(cur_req));
            if (!start || !busy)
            begin
                // hold off about one time in five unless in a burst
                if (pending_reqs.size() > 0 && (no_gaps || $urandom_range(99) >= 20))
                begin
                    cur_req       = pending_reqs.pop_front();
                    start         <= 1'b1;
                    mode          <= cur_req.mode;
                    slot          <= cur_req.slot;
                    pointer_value <= cur_req.ptr;
                    row_index     <= cur_req.row;
                    entry_value   <= cur_req.val;
                end
                else start <= 1'b0;
            end
        end
    end

    // Monitor: every done must match the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d", $time, status);
                failed = 1'b1;
            end
            else
            begin
                res_t e;
                e = expected_results.pop_front();
                if (status !== e.status)
                begin
                    $display("%0t: status exp %0d got %0d", $time, e.status, status);
                    failed = 1'b1;
                end
                if (col_index !== e.col)
                begin
                    $display("%0t: col_index exp %0d got %0d", $time, e.col, col_index);
                    failed = 1'b1;
                end
                if (out_value !== e.val)
                begin
                    $display("%0t: out_value exp %h got %h", $time, e.val, out_value);
                    failed = 1'b1;
                end
                if (row_pointer !== e.rp)
                begin
                    $display("%0t: row_pointer exp %0d got %0d", $time, e.rp, row_pointer);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog: cycles with neither a request taken nor a result seen.
    always @(posedge clk)
    begin
        if ((start && !busy) || done) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG)
        begin
            $display("[csc_to_csr_converter_unit] ERROR");
            $finish;
        end
    end

    // sample at the falling edge, once the driver's updates have settled
    task automatic wait_drain();
        @(negedge clk);
        while (pending_reqs.size() > 0 || expected_results.size() > 0 || start)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_config(int rows, int cols, int nnz);
        @(posedge clk);
        wr_en <= 1'b1; wr_index <= c2c_pkg::REG_NUM_ROWS;
        wr_data <= c2c_pkg::CFGDAT_W'(rows);
        @(posedge clk);
        wr_index <= c2c_pkg::REG_NUM_COLS; wr_data <= c2c_pkg::CFGDAT_W'(cols);
        @(posedge clk);
        wr_index <= c2c_pkg::REG_NUM_NONZEROS; wr_data <= c2c_pkg::CFGDAT_W'(nnz);
        @(posedge clk);
        wr_en <= 1'b0;
        rows_reg  = c2c_pkg::DIMREG_W'(rows);
        cols_reg  = c2c_pkg::DIMREG_W'(cols);
        nnz_reg   = c2c_pkg::NNZREG_W'(nnz);
        csr_ready = 1'b0;
    endtask

    function automatic req_t mk_req(logic [1:0] m, int s, int p, int r, logic [63:0] v);
        req_t q;
        q.mode = m;
        q.slot = c2c_pkg::SLOT_W'(s);
        q.ptr  = c2c_pkg::PTR_W'(p);
        q.row  = c2c_pkg::ROW_W'(r);
        q.val  = v;
        return q;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Noise: out-of-range loads (store nothing) and reads while not converted.
    function automatic req_t noise_req(bit reads_ok);
        case ($urandom_range(reads_ok ? 2 : 1))
            0: return mk_req(c2c_pkg::MODE_LOAD_PTR, $urandom_range(8191, DIM+1),
                             $urandom_range(8191), $urandom_range(255), rand64());
            1: return mk_req(c2c_pkg::MODE_LOAD_ENTRY, $urandom_range(8191, NNZ),
                             $urandom_range(8191), $urandom_range(255), rand64());
            default: return mk_req(c2c_pkg::MODE_READ, $urandom_range(8191),
                                   $urandom_range(8191), $urandom_range(255), rand64());
        endcase
    endfunction

    // One phase: configure, load pointers and entries, convert, drain, read back.
    task automatic run_phase(int rows, int cols, int nnz, bit wild_ptrs, int n_reads);
        int er, ec, en, s;
        int ptrs [$];
        write_config(rows, cols, nnz);
        er = eff_rows(); ec = eff_cols(); en = eff_nnz();
        ptrs.delete();
        for (int c = 0; c <= ec; c++)
            ptrs.push_back(wild_ptrs ? $urandom_range(8191) % (en + 3) : $urandom_range(en));
        if (!wild_ptrs)
        begin
            ptrs.sort();
            ptrs[0] = 0;
            ptrs[ec] = en;
        end
        for (int c = 0; c <= ec; c++)
        begin
            pending_reqs.push_back(mk_req(c2c_pkg::MODE_LOAD_PTR, c, ptrs[c],
                                          $urandom_range(255), rand64()));
            if ($urandom_range(9) == 0) pending_reqs.push_back(noise_req(1));
        end
        for (int n = 0; n < en; n++)
        begin
            // rows mostly in use, some outside to be skipped
            s = ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(er - 1);
            pending_reqs.push_back(mk_req(c2c_pkg::MODE_LOAD_ENTRY, n, $urandom_range(8191),
                                          s, rand64()));
            if ($urandom_range(9) == 0) pending_reqs.push_back(noise_req(1));
        end
        pending_reqs.push_back(mk_req(c2c_pkg::MODE_CONVERT, $urandom_range(8191),
                                      $urandom_range(8191), $urandom_range(255), rand64()));
        // the plan for reads needs the post-convert slot map, so drain first
        wait_drain();
        for (int i = 0; i < n_reads; i++)
        begin
            case ($urandom_range(3))
                0: s = $urandom_range(8191);
                1: s = $urandom_range(er + 1);
                default: s = (en > 0) ? $urandom_range(en - 1) : 0;
            endcase
            if (s < en && !csr_written[s]) s = en;
            pending_reqs.push_back(mk_req(c2c_pkg::MODE_READ, s, $urandom_range(8191),
                                          $urandom_range(255), rand64()));
            if ($urandom_range(14) == 0) pending_reqs.push_back(noise_req(0));
        end
        wait_drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        wr_en = 1'b0; wr_index = c2c_pkg::REG_NUM_ROWS; wr_data = '0;
        failed = 1'b0; quiet_cycles = 0; no_gaps = 1'b0;
        rows_reg = 1; cols_reg = 1; nnz_reg = 0; csr_ready = 1'b0;
        for (int i = 0; i < NNZ; i++) csr_written[i] = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: a read before any convert and out-of-range loads, then the smallest matrix
        pending_reqs.push_back(mk_req(c2c_pkg::MODE_READ, 0, 0, 0, '0));
        pending_reqs.push_back(mk_req(c2c_pkg::MODE_LOAD_PTR, 8191, 8191, 255, '1));
        pending_reqs.push_back(mk_req(c2c_pkg::MODE_LOAD_ENTRY, 4096, 0, 255, '1));
        wait_drain();
        run_phase(1, 1, 0, 1'b0, 6);
        run_phase(1, 1, 1, 1'b0, 6);
        // largest dimension register values, saturating to the maximum sizes
        run_phase(511, 511, 120, 1'b0, 80);
        // burst with no start gaps
        no_gaps = 1'b1;
        run_phase(8, 5, 40, 1'b0, 60);
        no_gaps = 1'b0;
        for (int p = 0; p < 12; p++)
            run_phase($urandom_range(24, 1), $urandom_range(24, 1), $urandom_range(60),
                      ($urandom_range(3) == 0), 25);

        wait_drain();
        repeat (20) @(posedge clk);
        if (!failed)
            $display("[csc_to_csr_converter_unit] OK");
        else
            $display("[csc_to_csr_converter_unit] ERROR");
        $finish;
    end

endmodule

### files.f
hdl/c2c_pkg.sv
hdl/c2c_ram.sv
hdl/csc_to_csr_converter_unit.sv
bench/tb_top.sv
